// ===== src/generation_tagged_probe_table_unit_defines.svh =====
// Assertion macros for the generation-tagged probe table.
// Used by the top level; samples on clk_i and is disabled while rst_ni is low.
`ifndef GENERATION_TAGGED_PROBE_TABLE_UNIT_DEFINES_SVH
`define GENERATION_TAGGED_PROBE_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checks a property on every rising edge of clk_i outside reset.
`define GTPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that a condition never holds on a rising edge of clk_i outside reset.
`define GTPT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define GTPT_ASSERT(lbl, prop, msg)
`define GTPT_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== src/gtpt_pkg.sv =====
// Package for the generation-tagged probe table: types, codes and constants.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package gtpt_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 1024;
  localparam logic [63:0] HASH_MULT = 64'd1099511628211;
  localparam int unsigned KEY_SHIFT = 4;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned GEN_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned SLOT_W = 10;

  typedef enum logic {
    CMD_ENSURE = 1'b0,
    CMD_GET    = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_HIT       = 3'd0,
    STAT_INSERTED  = 3'd1,
    STAT_REFRESHED = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_STALE     = 3'd4,
    STAT_FULL      = 3'd5,
    STAT_INVALID   = 3'd6
  } status_e;

  typedef struct packed {
    cmd_e              command;
    logic [KEY_W-1:0]  key;
    logic [GEN_W-1:0]  generation;
    logic [VAL_W-1:0]  new_value;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] slot;
  } out_item_t;

  // One table entry as it sits in the slot memory.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [GEN_W-1:0] generation;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/generation_tagged_probe_table_unit.sv =====
// Generation-tagged hash table with linear probing, one probe per cycle.
// The home slot is registered as a command transfers; S_HASH issues the first read and S_CHK
// walks 1 to TABLE_SLOTS slots before the result is registered; a zero key skips the probe.
// A new command is taken only in S_IDLE, once the previous result is in the result register.
// Reset: after rst_ni the block sweeps all TABLE_SLOTS entries to empty, one per cycle,
// and takes no command until that pass ends.
`timescale 1ns / 1ps
`default_nettype none
`include "generation_tagged_probe_table_unit_defines.svh"

module generation_tagged_probe_table_unit #(
  parameter int unsigned TABLE_SLOTS = gtpt_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire gtpt_pkg::in_item_t  in_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output gtpt_pkg::out_item_t      out_o
);
  import gtpt_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);

  // Controller states.
  localparam logic [1:0] S_CLR  = 2'd0;  // reset sweep over the slot memory
  localparam logic [1:0] S_IDLE = 2'd1;  // waiting for a command
  localparam logic [1:0] S_HASH = 2'd2;  // home slot known, first read issued
  localparam logic [1:0] S_CHK  = 2'd3;  // one slot examined per cycle

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [IDX_W-1:0] start_q, start_d;
  logic [IDX_W-1:0] ptr_nxt;
  logic [IDX_W-1:0] home;
  in_item_t         req_q;
  logic             in_fire;
  logic             out_free;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q;
  out_item_t        res;
  logic             out_load;

  // Slot memory: one entry of key, generation and value per slot.
  entry_t           mem_q [TABLE_SLOTS];
  entry_t           rd_data_q;
  entry_t           wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;

  logic             key_hit;
  logic             slot_empty;
  logic             gen_ok;
  logic             wrapped;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  // The result register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  assign ptr_nxt    = ptr_q + 1'b1;

  gtpt_hash #(
    .IDX_W (IDX_W)
  ) u_hash (
    .clk_i  (clk_i),
    .en_i   (in_fire),
    .key_i  (in_i.key),
    .home_o (home)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Compare the most recently read slot against the command.
  assign key_hit    = (rd_data_q.key == req_q.key);
  assign slot_empty = (rd_data_q.key == '0);
  assign gen_ok     = (rd_data_q.generation == req_q.generation);
  assign wrapped    = (ptr_nxt == start_q);

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    start_d    = start_q;
    rd_en      = 1'b0;
    rd_addr    = ptr_q;
    mem_we     = 1'b0;
    wr_addr    = ptr_q;
    wr_data    = '{key: req_q.key, generation: req_q.generation, value: req_q.new_value};
    out_load   = 1'b0;
    res.status = STAT_INVALID;
    res.value  = '0;
    res.slot   = '0;

    unique case (state_q)
      S_CLR: begin
        // Write an empty entry to every slot in turn.
        mem_we  = 1'b1;
        wr_data = '0;
        ptr_d   = ptr_nxt;
        if (ptr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (req_q.key == '0) begin
          // Zero is the empty marker and never a valid key.
          if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = home;
          ptr_d   = home;
          start_d = home;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (key_hit || slot_empty) begin
          // The probe ends here. The slot data stays put while the result
          // register is busy, so the decision is simply made again.
          res.slot = SLOT_W'(ptr_q);
          if (req_q.command == CMD_GET) begin
            if (slot_empty) begin
              res.status = STAT_NOT_FOUND;
              res.slot   = '0;
            end else if (gen_ok) begin
              res.status = STAT_HIT;
              res.value  = rd_data_q.value;
            end else begin
              res.status = STAT_STALE;
            end
          end else begin
            if (key_hit && gen_ok) begin
              res.status = STAT_HIT;
            end else if (key_hit) begin
              res.status = STAT_REFRESHED;
              res.value  = rd_data_q.value;
            end else begin
              res.status = STAT_INSERTED;
            end
          end
          if (out_free) begin
            out_load = 1'b1;
            mem_we   = (req_q.command == CMD_ENSURE) && !(key_hit && gen_ok);
            state_d  = S_IDLE;
          end
        end else if (wrapped) begin
          // Every slot was visited without meeting the key or a free slot.
          res.status = (req_q.command == CMD_ENSURE) ? STAT_FULL : STAT_NOT_FOUND;
          if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_nxt;
          ptr_d   = ptr_nxt;
        end
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      ptr_q       <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_i;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A result may only be loaded when the previous one has left.
  `GTPT_ASSERT(a_load_free, out_load |-> out_free, "result register overwritten")
  // Outside the reset sweep, the table changes only when an ensure completes.
  `GTPT_ASSERT(a_write_ensure, (mem_we && (state_q != S_CLR)) |-> (out_load && (req_q.command == CMD_ENSURE)), "unexpected table write")
  // A continued probe never steps back onto its home slot.
  `GTPT_ASSERT_NEVER(a_no_rewrap, (state_q == S_CHK) && rd_en && (ptr_nxt == start_q), "probe wrapped past home slot")
  // No traffic moves while the reset sweep runs.
  `GTPT_ASSERT(a_clear_quiet, (state_q == S_CLR) |-> (!in_ready_o && !out_valid_o), "transfer during clearing pass")

endmodule

`default_nettype wire

// ===== src/gtpt_hash.sv =====
// Home-slot hash of the probe table: low index bits of (key >> 4) * FNV prime.
// Depends on gtpt_pkg for the key width, shift and multiplier.
`timescale 1ns / 1ps
`default_nettype none

module gtpt_hash #(
  parameter int unsigned IDX_W = 10
) (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [gtpt_pkg::KEY_W-1:0] key_i,
  output logic      [IDX_W-1:0]          home_o
);
  import gtpt_pkg::*;

  localparam logic [IDX_W-1:0] MULT_LO = HASH_MULT[IDX_W-1:0];

  logic [IDX_W-1:0] key_lo;
  logic [IDX_W-1:0] home_d;
  logic [IDX_W-1:0] home_q;

  // Only the low index bits of the product are kept, so only the low index
  // bits of both operands take part.
  assign key_lo = key_i[KEY_SHIFT +: IDX_W];
  assign home_d = IDX_W'(key_lo * MULT_LO);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      home_q <= home_d;
    end
  end

  assign home_o = home_q;

endmodule

`default_nettype wire
